>>> sv/mig_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_pkg
// shared constants, types and command/status structs for the inverter
// ----------------------------------------------------------------------------
package mig_pkg;

  localparam int DefMaxSize  = 8;
  localparam int DefFracBits = 16;
  localparam int DataW       = 32;
  localparam int SizeW       = 4;
  localparam int DivIters    = 64;

  typedef enum logic [2:0] {
    OP_NONE = 3'b001,
    OP_DIV  = 3'b010,
    OP_MSUB = 3'b100
  } op_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] c;
  } dp_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] res;
  } dp_sts_t;

  function automatic logic [DataW-1:0] sat32(input logic signed [65:0] v);
    logic [DataW-1:0] r;
    if (v > 66'sh7FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -66'sh80000000) r = 32'h80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage : mig_pkg
`default_nettype wire

>>> sv/mig_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_datapath
// shared arithmetic unit: restoring divider (one bit a cycle) and a
// multiply-subtract in three registered steps
// ----------------------------------------------------------------------------
module mig_datapath
  import mig_pkg::*;
#(
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts
);

  localparam int QW = DataW + FRAC_BITS + 1;
  localparam int XW = 66 - QW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_RND  = 5'b01000,
    S_SUB  = 5'b10000
  } dst_t;

  dst_t state_r, state_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [QW-1:0]       num_r, num_nxt;
  logic [QW-1:0]       quo_r, quo_nxt;
  logic [DataW-1:0]    rem_r, rem_nxt;
  logic [DataW-1:0]    den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [63:0]         prod_r, prod_nxt;
  logic [DataW-1:0]    acc_r, acc_nxt;
  logic [DataW-1:0]    res_r, res_nxt;
  logic                done_r, done_nxt;

  logic [DataW-1:0] ma, mb, mc;
  logic [DataW:0]   trial;
  logic [63:0]      rnd;
  logic signed [65:0] sq, sdiff;
  logic [63:0]      numer_full;

  assign ma = cmd.a[DataW-1] ? (~cmd.a + 1'b1) : cmd.a;
  assign mb = cmd.b[DataW-1] ? (~cmd.b + 1'b1) : cmd.b;
  assign mc = cmd.c[DataW-1] ? (~cmd.c + 1'b1) : cmd.c;
  assign numer_full = ({32'd0, ma} << FRAC_BITS) + {33'd0, mb[DataW-1:1]};

  always_comb begin
    trial = {rem_r, num_r[QW-1]};
    rnd   = (prod_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    sq    = neg_r ? -$signed({{XW{1'b0}}, quo_r}) :
                     $signed({{XW{1'b0}}, quo_r});
    sdiff = $signed({{34{acc_r[DataW-1]}}, acc_r}) -
            (neg_r ? -$signed({2'b00, prod_r}) : $signed({2'b00, prod_r}));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; num_nxt = num_r; quo_nxt = quo_r; rem_nxt = rem_r;
    den_nxt = den_r; neg_nxt = neg_r; prod_nxt = prod_r; acc_nxt = acc_r;
    res_nxt = res_r; done_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start && cmd.op == OP_DIV) begin
          num_nxt   = QW'(numer_full);
          quo_nxt   = '0;
          rem_nxt   = '0;
          den_nxt   = mb;
          neg_nxt   = cmd.a[DataW-1] ^ cmd.b[DataW-1];
          cnt_nxt   = 7'(QW);
          state_nxt = S_DIV;
        end else if (cmd.start && cmd.op == OP_MSUB) begin
          prod_nxt  = {32'd0, mb} * {32'd0, mc};
          neg_nxt   = cmd.b[DataW-1] ^ cmd.c[DataW-1];
          acc_nxt   = cmd.a;
          state_nxt = S_RND;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = DataW'(trial - {1'b0, den_r});
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DataW-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        num_nxt = {num_r[QW-2:0], 1'b0};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) state_nxt = S_SUB;
      end
      S_RND: begin
        prod_nxt  = rnd;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        res_nxt   = sat32(sdiff);
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SUB: begin
        res_nxt   = sat32(sq);
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt; num_r <= num_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    den_r <= den_nxt; neg_r <= neg_nxt; prod_r <= prod_nxt; acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign sts.done = done_r;
  assign sts.res  = res_r;

endmodule : mig_datapath
`default_nettype wire

>>> sv/mig_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_ctrl
// load, elimination sequencing and readout; owns the two matrix memories
// ----------------------------------------------------------------------------
module mig_ctrl
  import mig_pkg::*;
#(
  parameter int MAX_SIZE  = DefMaxSize,
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [SizeW-1:0] cfg_wdata,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [DataW-1:0] in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [DataW-1:0]      out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast,
  output dp_cmd_t               cmd,
  input  wire dp_sts_t          sts
);

  localparam int IW    = $clog2(MAX_SIZE);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = (IW + 1 > SizeW) ? IW + 1 : SizeW;

  typedef enum logic [12:0] {
    C_LOAD  = 13'b0000000000001,
    C_INIT  = 13'b0000000000010,
    C_PIVRD = 13'b0000000000100,
    C_PIV   = 13'b0000000001000,
    C_DIVRD = 13'b0000000010000,
    C_DIV   = 13'b0000000100000,
    C_MRD   = 13'b0000001000000,
    C_MGET  = 13'b0000010000000,
    C_URD   = 13'b0000100000000,
    C_UOP   = 13'b0001000000000,
    C_NEXT  = 13'b0010000000000,
    C_ORD   = 13'b0100000000000,
    C_OUT   = 13'b1000000000000
  } cst_t;

  logic [DataW-1:0] wmem [DEPTH];
  logic [DataW-1:0] imem [DEPTH];

  cst_t state_r, state_nxt;
  logic [SW-1:0]    size_r, size_nxt;
  logic [IW:0]      n;
  logic [IW-1:0]    lr_r, lr_nxt, lc_r, lc_nxt;
  logic [IW-1:0]    k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic             half_r, half_nxt, back_r, back_nxt;
  logic             sing_r, sing_nxt;
  logic [DataW-1:0] piv_r, piv_nxt, m_r, m_nxt;
  logic             started_r, started_nxt;

  logic             wwe, iwe;
  logic [AW-1:0]    wwa, iwa, ra0, ra1;
  logic [DataW-1:0] wwd, iwd;
  logic [DataW-1:0] w0_r, w1_r, i0_r, i1_r;
  logic [IW-1:0]    lastidx;
  logic             out_last;

  always_comb begin
    if (size_r == '0) n = (IW+1)'(1);
    else if (size_r > SW'(MAX_SIZE)) n = (IW+1)'(MAX_SIZE);
    else n = (IW+1)'(size_r);
  end
  assign lastidx = IW'(n - 1'b1);

  function automatic logic [AW-1:0] adr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return {r, c};
  endfunction

  always_ff @(posedge clk) begin
    if (wwe) wmem[wwa] <= wwd;
    if (iwe) imem[iwa] <= iwd;
    w0_r <= wmem[ra0];
    w1_r <= wmem[ra1];
    i0_r <= imem[ra0];
    i1_r <= imem[ra1];
  end

  assign out_last = (lr_r == lastidx) && (lc_r == lastidx);

  always_comb begin
    state_nxt = state_r; size_nxt = size_r;
    lr_nxt = lr_r; lc_nxt = lc_r; k_nxt = k_r; i_nxt = i_r; j_nxt = j_r;
    half_nxt = half_r; back_nxt = back_r; sing_nxt = sing_r;
    piv_nxt = piv_r; m_nxt = m_r; started_nxt = 1'b0;
    wwe = 1'b0; iwe = 1'b0; wwa = '0; iwa = '0; wwd = in_tdata; iwd = '0;
    ra0 = '0; ra1 = '0;
    cmd = '{start: 1'b0, op: OP_NONE, a: '0, b: '0, c: '0};
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      C_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          wwe = 1'b1; wwa = adr(lr_r, lc_r);
          if (lc_r == lastidx) begin
            lc_nxt = '0;
            if (lr_r == lastidx) begin
              lr_nxt = '0; state_nxt = C_INIT; sing_nxt = 1'b0;
            end else lr_nxt = lr_r + 1'b1;
          end else lc_nxt = lc_r + 1'b1;
        end
      end
      C_INIT: begin
        iwe = 1'b1; iwa = adr(lr_r, lc_r);
        iwd = (lr_r == lc_r) ? DataW'(64'd1 << FRAC_BITS) : '0;
        if (lc_r == lastidx) begin
          lc_nxt = '0;
          if (lr_r == lastidx) begin
            lr_nxt = '0; k_nxt = '0; back_nxt = 1'b0; state_nxt = C_PIVRD;
          end else lr_nxt = lr_r + 1'b1;
        end else lc_nxt = lc_r + 1'b1;
      end
      C_PIVRD: begin
        ra0 = adr(k_r, k_r); state_nxt = C_PIV;
      end
      C_PIV: begin
        piv_nxt = w0_r; j_nxt = '0; half_nxt = 1'b0;
        if (w0_r == '0) begin
          sing_nxt = 1'b1; i_nxt = k_r; state_nxt = C_NEXT;
        end else state_nxt = C_DIVRD;
      end
      C_DIVRD: begin
        ra0 = adr(k_r, j_r); state_nxt = C_DIV; started_nxt = 1'b1;
      end
      C_DIV: begin
        cmd.op = OP_DIV; cmd.a = half_r ? i0_r : w0_r; cmd.b = piv_r;
        cmd.start = started_r;
        if (sts.done) begin
          wwa = adr(k_r, j_r); iwa = wwa; wwd = sts.res; iwd = sts.res;
          wwe = !half_r; iwe = half_r;
          if (!half_r) half_nxt = 1'b1;
          else begin
            half_nxt = 1'b0;
            if (j_r == lastidx) begin
              i_nxt = k_r; state_nxt = C_NEXT;
            end else j_nxt = j_r + 1'b1;
          end
          if (state_nxt != C_NEXT) state_nxt = C_DIVRD;
        end
      end
      C_NEXT: begin
        // pick the next row to update for pivot k, else advance the pivot or go to readout
        if (!back_r) begin
          if (i_r == lastidx) begin
            if (k_r == lastidx) begin
              back_nxt = 1'b1;
              if (k_r == '0) begin
                state_nxt = C_ORD; lr_nxt = '0; lc_nxt = '0;
              end else begin
                i_nxt = k_r - 1'b1; state_nxt = C_MRD;
              end
            end else begin
              k_nxt = k_r + 1'b1; state_nxt = C_PIVRD;
            end
          end else begin
            i_nxt = i_r + 1'b1; state_nxt = C_MRD;
          end
        end else begin
          if (i_r == '0) begin
            if (k_r == IW'(1)) begin
              state_nxt = C_ORD; lr_nxt = '0; lc_nxt = '0;
            end else begin
              k_nxt = k_r - 1'b1; i_nxt = k_r - IW'(2); state_nxt = C_MRD;
            end
          end else begin
            i_nxt = i_r - 1'b1; state_nxt = C_MRD;
          end
        end
      end
      C_MRD: begin
        ra0 = adr(i_r, k_r); state_nxt = C_MGET;
      end
      C_MGET: begin
        m_nxt = w0_r; j_nxt = '0; half_nxt = 1'b0; state_nxt = C_URD;
      end
      C_URD: begin
        ra0 = adr(i_r, j_r); ra1 = adr(k_r, j_r); state_nxt = C_UOP;
        started_nxt = 1'b1;
      end
      C_UOP: begin
        cmd.op = OP_MSUB; cmd.start = started_r;
        cmd.a = half_r ? i0_r : w0_r; cmd.b = half_r ? i1_r : w1_r; cmd.c = m_r;
        if (sts.done) begin
          wwa = adr(i_r, j_r); iwa = wwa; wwd = sts.res; iwd = sts.res;
          wwe = !half_r; iwe = half_r;
          state_nxt = C_URD;
          if (!half_r) half_nxt = 1'b1;
          else begin
            half_nxt = 1'b0;
            if (j_r == lastidx) state_nxt = C_NEXT;
            else j_nxt = j_r + 1'b1;
          end
        end
      end
      C_ORD: begin
        ra0 = adr(lr_r, lc_r); state_nxt = C_OUT;
      end
      C_OUT: begin
        out_tvalid = 1'b1;
        ra0 = adr(lr_r, lc_r);
        if (out_tready) begin
          state_nxt = C_ORD;
          if (lc_r == lastidx) begin
            lc_nxt = '0;
            if (lr_r == lastidx) begin
              lr_nxt = '0; state_nxt = C_LOAD;
            end else lr_nxt = lr_r + 1'b1;
          end else lc_nxt = lc_r + 1'b1;
        end
      end
      default: state_nxt = C_LOAD;
    endcase
    if (cfg_we) begin
      size_nxt = SW'(cfg_wdata);
      if (state_r == C_LOAD) begin
        lr_nxt = '0; lc_nxt = '0;
      end
    end
  end

  assign out_tdata = sing_r ? '0 : i0_r;
  assign out_tuser = sing_r;
  assign out_tlast = out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_LOAD; size_r <= SW'(MAX_SIZE);
      lr_r <= '0; lc_r <= '0; sing_r <= 1'b0; started_r <= 1'b0;
    end else begin
      state_r <= state_nxt; size_r <= size_nxt;
      lr_r <= lr_nxt; lc_r <= lc_nxt; sing_r <= sing_nxt; started_r <= started_nxt;
    end
    k_r <= k_nxt; i_r <= i_nxt; j_r <= j_nxt; half_r <= half_nxt;
    back_r <= back_nxt; piv_r <= piv_nxt; m_r <= m_nxt;
  end

endmodule : mig_ctrl
`default_nettype wire

>>> sv/matrix_inversion_gauss_jordan_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inversion_gauss_jordan_top
// Gauss-Jordan inverse of a signed Q16.16 matrix, no pivoting
// ----------------------------------------------------------------------------
// Usage: write matrix_size on cfg_we/cfg_wdata while idle; a write also drops
// a partly loaded matrix. Stream n*n words row-major on in_*; one is taken per
// cycle. After the last word the sequencer runs: identity fill of the n*n
// inverse, then the 2n*n divisions (bit-serial divider) and about 2n^3
// multiply-subtracts, all on one shared arithmetic unit. The inverse leaves
// on out_* row-major, tlast on the final word, tuser set with zero data when
// a zero pivot was met. Each output word is first read from memory and then
// presented; a stalled receiver simply holds it. No input is taken from the
// last load until the final output word leaves.
// Reset (rst_n low, synchronous) returns to loading, matrix_size = MAX_SIZE.
// ----------------------------------------------------------------------------
module matrix_inversion_gauss_jordan_top
  import mig_pkg::*;
#(
  parameter int MAX_SIZE  = DefMaxSize,
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [SizeW-1:0] cfg_wdata,   // matrix_size
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [DataW-1:0] in_tdata,    // elem_value
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [DataW-1:0]      out_tdata,   // inv_value
  output logic                  out_tuser,   // singular
  output logic                  out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mig_ctrl #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast, .cmd, .sts
  );

  mig_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts
  );

endmodule : matrix_inversion_gauss_jordan_top
`default_nettype wire

>>> sv/mig_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mig_checker
// port-level properties of the inverter
// ----------------------------------------------------------------------------
module mig_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken during output");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0)) else $error("singular data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled word changed");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("output after last");

endmodule : mig_checker

bind matrix_inversion_gauss_jordan_top mig_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser,
  .out_tlast
);
`default_nettype wire
